[hw/rtl/lbmq_pkg.sv]
`timescale 1ns / 1ps
package lbmq_pkg;
  localparam int BIN_COUNT = 4;
  localparam int BIN_DEPTH = 256;
  localparam int BIN_W = $clog2(BIN_COUNT);
  localparam int SLOT_W = $clog2(BIN_DEPTH);
  localparam int CNT_W = $clog2(BIN_DEPTH + 1);
  localparam int ADDR_W = BIN_W + SLOT_W;
  localparam int MEM_DEPTH = BIN_COUNT * BIN_DEPTH;
  localparam int MEM_W = 48;
  localparam int TOT_W = 11;
  localparam int NUM_REGS = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_GAP = 2'd3;

  typedef struct packed {
    logic load;
    logic finish;
  } ctrl_t;
endpackage

[hw/rtl/length_binned_multiqueue_unit.sv]
`timescale 1ns / 1ps
// Length-binned multi-queue: four FIFO bins of 256 items, each covering a
// programmed length interval.
// Commands enter on start while busy is low: operation selects insert, pop
// or peek, with item_length and item_tag for inserts.
// The decision (bin choice, full and gap checks, head and count updates) is
// made in the accept cycle; the following cycle reads the item memory.
// The result appears on the port with done high for one cycle, registered
// after the memory read state. No new command is accepted while that read
// state holds busy high.
// The receiver cannot stall; each result must be taken when done is high.
// Bin bounds are written through APB at byte addresses 4*i, low/high of bin 0
// up to bin 3; the user must do so only while idle, unenforced by the block.
// Reset clears the counts, heads and bounds; the item memory is not cleared
// since an entry is only read after it was written.
module length_binned_multiqueue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] item_length,
  input  logic [15:0] item_tag,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] out_tag,
  output logic [31:0] out_length,
  output logic [1:0]  chosen_bin,
  output logic [10:0] total_count,
  output logic        all_empty,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] regs [lbmq_pkg::NUM_REGS];
  logic [31:0] lows [lbmq_pkg::BIN_COUNT];
  logic [31:0] highs [lbmq_pkg::BIN_COUNT];
  lbmq_pkg::ctrl_t ctrl;

  assign pready = 1'b1;
  assign prdata = regs[paddr[4:2]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lbmq_pkg::NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      regs[paddr[4:2]] <= pwdata;
    end
  end

  always_comb begin
    for (int i = 0; i < lbmq_pkg::BIN_COUNT; i++) begin
      lows[i] = regs[2*i];
      highs[i] = regs[2*i+1];
    end
  end

  lbmq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  lbmq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .operation   (operation),
    .item_length (item_length),
    .item_tag    (item_tag),
    .lows        (lows),
    .highs       (highs),
    .done        (done),
    .status      (status),
    .out_tag     (out_tag),
    .out_length  (out_length),
    .chosen_bin  (chosen_bin),
    .total_count (total_count),
    .all_empty   (all_empty)
  );
endmodule

[hw/rtl/lbmq_ram.sv]
`timescale 1ns / 1ps
module lbmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/lbmq_ctrl.sv]
`timescale 1ns / 1ps
module lbmq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output lbmq_pkg::ctrl_t  ctrl
);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state == S_READ);
  assign ctrl.load = (state == S_IDLE) && start;
  assign ctrl.finish = (state == S_READ);
endmodule

[hw/rtl/lbmq_dp.sv]
`timescale 1ns / 1ps
module lbmq_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  lbmq_pkg::ctrl_t                ctrl,
  input  logic [1:0]                     operation,
  input  logic [31:0]                    item_length,
  input  logic [15:0]                    item_tag,
  input  logic [31:0]                    lows [lbmq_pkg::BIN_COUNT],
  input  logic [31:0]                    highs [lbmq_pkg::BIN_COUNT],
  output logic                           done,
  output logic [1:0]                     status,
  output logic [15:0]                    out_tag,
  output logic [31:0]                    out_length,
  output logic [1:0]                     chosen_bin,
  output logic [lbmq_pkg::TOT_W-1:0]     total_count,
  output logic                           all_empty
);
  localparam int NB = lbmq_pkg::BIN_COUNT;
  localparam int BW = lbmq_pkg::BIN_W;
  localparam int CW = lbmq_pkg::CNT_W;
  localparam int SW = lbmq_pkg::SLOT_W;

  logic [SW-1:0] heads [NB];
  logic [CW-1:0] counts [NB];
  logic [lbmq_pkg::TOT_W-1:0] total;

  logic [NB-1:0] hold;
  logic [NB-1:0] nonempty;
  logic          found;
  logic [BW-1:0] front, back;
  logic [BW-1:0] pick;
  logic [BW-1:0] first_ne;
  logic          any_ne;

  // Lookup of the bin run, written the way the binary search resolves.
  always_comb begin
    int lo, hi, mid, f, b, k;
    logic stop;
    found = 1'b0;
    front = '0;
    back = '0;
    for (int i = 0; i < NB; i++) begin
      hold[i] = (lows[i] <= item_length) && (highs[i] >= item_length);
      nonempty[i] = (counts[i] != '0);
    end
    any_ne = |nonempty;
    first_ne = BW'(NB - 1);
    for (int i = NB - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        first_ne = BW'(i);
      end
    end
    lo = 0;
    hi = NB - 1;
    mid = 0;
    k = 0;
    f = 0;
    b = 0;
    stop = 1'b0;
    if (item_length < lows[0]) begin
      found = 1'b1;
      front = first_ne;
      back = first_ne;
    end else if (item_length > lows[NB-1]) begin
      found = 1'b1;
      for (int i = 0; i < NB; i++) begin
        if (nonempty[i]) begin
          k = i;
        end
      end
      front = '0;
      back = BW'(k);
    end else begin
      for (int s = 0; s < BW + 1; s++) begin
        if (!stop && lo <= hi) begin
          mid = (lo + hi) / 2;
          if (hold[mid]) begin
            found = 1'b1;
            stop = 1'b1;
            f = mid;
            b = mid;
          end else if (item_length < lows[mid] && mid > 0) begin
            hi = mid - 1;
          end else if (item_length > highs[mid] && mid < NB - 1) begin
            lo = mid + 1;
          end else begin
            stop = 1'b1;
          end
        end
      end
      if (found) begin
        for (int i = NB - 1; i >= 0; i--) begin
          if (i < f && i == f - 1 && hold[i]) begin
            f = i;
          end
        end
        for (int i = 0; i < NB; i++) begin
          if (i > b && i == b + 1 && hold[i]) begin
            b = i;
          end
        end
        front = BW'(f);
        back = BW'(b);
      end
    end
  end

  // Least-filled bin of the run, middle of the ties.
  always_comb begin
    logic [CW-1:0] minv;
    logic [NB-1:0] tie;
    int nt, want, seen;
    minv = '1;
    tie = '0;
    nt = 0;
    seen = 0;
    pick = front;
    for (int i = 0; i < NB; i++) begin
      if (BW'(i) >= front && BW'(i) <= back && counts[i] < minv) begin
        minv = counts[i];
      end
    end
    for (int i = 0; i < NB; i++) begin
      tie[i] = BW'(i) >= front && BW'(i) <= back && counts[i] == minv;
      if (tie[i]) begin
        nt = nt + 1;
      end
    end
    want = nt / 2;
    for (int i = 0; i < NB; i++) begin
      if (tie[i]) begin
        if (seen == want) begin
          pick = BW'(i);
        end
        seen = seen + 1;
      end
    end
  end

  // Registered decision taken at accept time.
  logic [BW-1:0] bin_q;
  logic [1:0]    st_q;
  logic          rd_q;
  logic          we;
  logic [lbmq_pkg::ADDR_W-1:0] waddr, raddr;
  logic [lbmq_pkg::MEM_W-1:0]  rdata;
  logic [SW-1:0] slot;

  assign slot = heads[pick] + SW'(counts[pick]);
  assign waddr = {pick, slot};
  assign raddr = {first_ne, heads[first_ne]};
  assign we = ctrl.load && operation == lbmq_pkg::OP_INSERT && found
              && counts[pick] != CW'(lbmq_pkg::BIN_DEPTH);

  lbmq_ram #(.WIDTH(lbmq_pkg::MEM_W), .DEPTH(lbmq_pkg::MEM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({item_tag, item_length}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NB; i++) begin
        heads[i] <= '0;
        counts[i] <= '0;
      end
      total <= '0;
      done <= 1'b0;
    end else begin
      done <= ctrl.finish;
      if (ctrl.load) begin
        unique case (operation)
          lbmq_pkg::OP_INSERT: begin
            if (we) begin
              counts[pick] <= counts[pick] + 1'b1;
              total <= total + 1'b1;
            end
          end
          lbmq_pkg::OP_POP: begin
            if (any_ne) begin
              heads[first_ne] <= heads[first_ne] + 1'b1;
              counts[first_ne] <= counts[first_ne] - 1'b1;
              total <= total - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rd_q <= 1'b0;
      bin_q <= '0;
      st_q <= lbmq_pkg::ST_OK;
      case (operation)
        lbmq_pkg::OP_INSERT: begin
          if (!found) begin
            st_q <= lbmq_pkg::ST_GAP;
          end else begin
            bin_q <= pick;
            if (!we) begin
              st_q <= lbmq_pkg::ST_FULL;
            end
          end
        end
        lbmq_pkg::OP_POP, lbmq_pkg::OP_PEEK: begin
          if (!any_ne) begin
            st_q <= lbmq_pkg::ST_EMPTY;
          end else begin
            bin_q <= first_ne;
            rd_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      status <= st_q;
      chosen_bin <= 2'(bin_q);
      out_tag <= rd_q ? rdata[47:32] : 16'd0;
      out_length <= rd_q ? rdata[31:0] : 32'd0;
      total_count <= total;
      all_empty <= (total == '0);
    end
  end
endmodule

[hw/rtl/lbmq_checker.sv]
`timescale 1ns / 1ps
module lbmq_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [10:0] total_count,
  input logic        all_empty
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done) else $error("result missing");
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (all_empty == (total_count == 11'd0))) else $error("all_empty wrong");
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    done && status == lbmq_pkg::ST_EMPTY |-> all_empty)
    else $error("empty status with items");
endmodule

bind length_binned_multiqueue_unit lbmq_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .total_count(total_count), .all_empty(all_empty)
);

[tb/length_binned_multiqueue_checker.sv]
`timescale 1ns / 1ps
module length_binned_multiqueue_checker
  import lbmq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] item_length,
  input  logic [15:0] item_tag,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [15:0] out_tag,
  input  logic [31:0] out_length,
  input  logic [1:0]  chosen_bin,
  input  logic [10:0] total_count,
  input  logic        all_empty,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tag;
    logic [31:0] len;
    logic [1:0]  bin;
    logic [10:0] total;
    logic        empty;
  } queue_result_t;

  logic [31:0] low_bound [BIN_COUNT];
  logic [31:0] high_bound [BIN_COUNT];
  logic [15:0] slot_tag [MEM_DEPTH];
  logic [31:0] slot_len [MEM_DEPTH];
  logic [SLOT_W-1:0] head [BIN_COUNT];
  int fill [BIN_COUNT];
  queue_result_t expected_results [$];

  function automatic bit covers(int b, logic [31:0] l);
    return low_bound[b] <= l && high_bound[b] >= l;
  endfunction

  // Finds the run of bins for an insert; returns 0 when the length falls in a gap.
  function automatic bit find_bins(logic [31:0] l, output int first, output int last);
    int lo, hi, mid, i;
    lo = 0;
    hi = BIN_COUNT - 1;
    first = 0;
    last = 0;
    if (l < low_bound[0]) begin
      i = 0;
      while (fill[i] == 0 && i + 1 < BIN_COUNT) i++;
      first = i;
      last = i;
      return 1;
    end
    if (l > low_bound[BIN_COUNT-1]) begin
      i = BIN_COUNT - 1;
      while (fill[i] == 0 && i > 0) i--;
      last = i;
      return 1;
    end
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (covers(mid, l)) begin
        first = mid;
        last = mid;
        while (first > 0 && covers(first - 1, l)) first--;
        while (last + 1 < BIN_COUNT && covers(last + 1, l)) last++;
        return 1;
      end else if (l < low_bound[mid] && mid > 0) begin
        hi = mid - 1;
      end else if (l > high_bound[mid] && mid < BIN_COUNT - 1) begin
        lo = mid + 1;
      end else begin
        return 0;
      end
    end
    return 0;
  endfunction

  function automatic queue_result_t apply_command(logic [1:0] op, logic [31:0] l,
                                                  logic [15:0] t);
    queue_result_t r;
    int first, last, i, pick, n, least, total, addr;
    int ties [BIN_COUNT];
    r = '0;
    if (op == OP_INSERT) begin
      if (!find_bins(l, first, last)) begin
        r.status = ST_GAP;
      end else begin
        least = 32'h7fffffff;
        n = 0;
        for (i = first; i <= last; i++) begin
          if (fill[i] < least) begin
            least = fill[i];
            n = 0;
            ties[n++] = i;
          end else if (fill[i] == least) begin
            ties[n++] = i;
          end
        end
        pick = ties[n / 2];
        r.bin = pick[1:0];
        if (fill[pick] >= BIN_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          addr = pick * BIN_DEPTH + ((head[pick] + fill[pick]) % BIN_DEPTH);
          slot_tag[addr] = t;
          slot_len[addr] = l;
          fill[pick]++;
        end
      end
    end else if (op == OP_POP || op == OP_PEEK) begin
      pick = -1;
      for (i = BIN_COUNT - 1; i >= 0; i--) if (fill[i] != 0) pick = i;
      if (pick < 0) begin
        r.status = ST_EMPTY;
      end else begin
        addr = pick * BIN_DEPTH + head[pick];
        r.tag = slot_tag[addr];
        r.len = slot_len[addr];
        r.bin = pick[1:0];
        if (op == OP_POP) begin
          head[pick] = head[pick] + 1'b1;
          fill[pick]--;
        end
      end
    end
    total = 0;
    for (i = 0; i < BIN_COUNT; i++) total += fill[i];
    r.total = total[10:0];
    r.empty = (total == 0);
    return r;
  endfunction

  assign outstanding = expected_results.size();

  always @(posedge clk) begin
    queue_result_t got, want;
    if (rst) begin
      for (int i = 0; i < BIN_COUNT; i++) begin
        low_bound[i] = '0;
        high_bound[i] = '0;
        head[i] = '0;
        fill[i] = 0;
      end
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[4:2] < NUM_REGS) begin
        if (paddr[2]) high_bound[paddr[4:3]] = pwdata;
        else low_bound[paddr[4:3]] = pwdata;
      end
      if (done) begin
        got = '{status, out_tag, out_length, chosen_bin, total_count, all_empty};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: status %0d/%0d tag %h/%h len %h/%h bin %0d/%0d",
                        " total %0d/%0d empty %0d/%0d (exp/act)"},
                       want.status, got.status, want.tag, got.tag, want.len, got.len,
                       want.bin, got.bin, want.total, got.total, want.empty, got.empty);
          end
        end
      end
      if (start && !busy)
        expected_results = {expected_results,
                            apply_command(operation, item_length, item_tag)};
    end
  end

endmodule

[tb/length_binned_multiqueue_unit_tb.sv]
`timescale 1ns / 1ps
module length_binned_multiqueue_unit_tb;
  import lbmq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] operation = OP_INSERT;
  logic [31:0] item_length = '0;
  logic [15:0] item_tag = '0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy, done, pready, all_empty;
  logic [1:0] status, chosen_bin;
  logic [15:0] out_tag;
  logic [31:0] out_length, prdata;
  logic [10:0] total_count;
  int fail_count, outstanding;
  int cycles = 0;
  int idle_pct = 0;
  logic [31:0] bounds [NUM_REGS];

  localparam int CYCLE_LIMIT = 300000;

  always #4 clk = ~clk;

  length_binned_multiqueue_unit dut (.*);
  length_binned_multiqueue_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("length_binned_multiqueue_unit_tb failed");
      $finish;
    end
  end

  // Called just after a falling edge; returns just after the falling edge that
  // follows the accepting rising edge.
  task automatic send(logic [1:0] op, logic [31:0] l, logic [15:0] t);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    if (busy) begin
      start = 0;
      while (busy) @(negedge clk);
    end
    start = 1;
    operation = op;
    item_length = l;
    item_tag = t;
    @(negedge clk);
  endtask

  task automatic drain();
    start = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] v);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = 5'(idx * 4);
    pwdata = v;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    bounds[idx] = v;
  endtask

  task automatic program_bins(logic [31:0] l0, h0, l1, h1, l2, h2, l3, h3);
    drain();
    write_reg(0, l0); write_reg(1, h0); write_reg(2, l1); write_reg(3, h1);
    write_reg(4, l2); write_reg(5, h2); write_reg(6, l3); write_reg(7, h3);
  endtask

  // Lengths cluster on the programmed bounds so that runs, gaps and edges are hit.
  function automatic logic [31:0] pick_length();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'd0 : 32'hffffffff;
      default: return bounds[$urandom_range(NUM_REGS - 1)] + 32'($signed($urandom_range(4)) - 2);
    endcase
  endfunction

  task automatic random_items(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 50) send(OP_INSERT, pick_length(), 16'($urandom));
      else if (r < 80) send(OP_POP, $urandom, 16'($urandom));
      else if (r < 95) send(OP_PEEK, $urandom, 16'($urandom));
      else send(OP_UNUSED, $urandom, 16'($urandom));
    end
  endtask

  task automatic random_bins();
    logic [31:0] b;
    b = $urandom_range(20);
    for (int i = 0; i < BIN_COUNT; i++) begin
      bounds[2*i] = b;
      bounds[2*i+1] = b + $urandom_range(60);
      b = b + $urandom_range(50);
    end
    program_bins(bounds[0], bounds[1], bounds[2], bounds[3],
                 bounds[4], bounds[5], bounds[6], bounds[7]);
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) bounds[i] = '0;
    repeat (7) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // Directed: empty reads, the unused operation, overlapping runs with tie
    // breaking, a gap, lengths below and above all bounds, and field extremes.
    send(OP_POP, '0, '0);
    send(OP_PEEK, '0, '0);
    send(OP_UNUSED, 32'hffffffff, 16'hffff);
    send(OP_INSERT, 32'd0, 16'h0000);
    program_bins(10, 20, 15, 30, 40, 50, 50, 100);
    send(OP_INSERT, 32'd5, 16'h1111);
    send(OP_INSERT, 32'd12, 16'hffff);
    send(OP_INSERT, 32'd17, 16'h0001);
    send(OP_INSERT, 32'd18, 16'h0002);
    send(OP_INSERT, 32'd35, 16'h0003);
    send(OP_INSERT, 32'd50, 16'h0004);
    send(OP_INSERT, 32'd50, 16'h0005);
    send(OP_INSERT, 32'd200, 16'h0006);
    send(OP_INSERT, 32'hffffffff, 16'h0007);
    send(OP_INSERT, 32'd0, 16'h0008);
    send(OP_PEEK, '0, '0);
    for (int i = 0; i < 6; i++) send(OP_POP, '0, '0);
    send(OP_PEEK, '0, '0);

    program_bins('1, '1, '1, '1, '1, '1, '1, '1);
    idle_pct = 85;
    random_items(60);
    program_bins('0, '0, '0, '0, '0, '0, '0, '0);
    idle_pct = 0;
    random_items(60);

    // Fill bin 0 past its depth, then empty it.
    program_bins(100, 100, 200, 300, 200, 300, 200, 300);
    idle_pct = 15;
    for (int i = 0; i < BIN_DEPTH + 4; i++) send(OP_INSERT, 32'd100, 16'($urandom));
    for (int i = 0; i < BIN_DEPTH + 4; i++) send(OP_POP, '0, '0);

    for (int p = 0; p < 6; p++) begin
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 85;
        default: idle_pct = 15;
      endcase
      if (p == 5)
        program_bins($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
      else
        random_bins();
      random_items(80);
    end

    drain();
    if (fail_count == 0) $display("length_binned_multiqueue_unit_tb passed");
    else $display("length_binned_multiqueue_unit_tb failed");
    $finish;
  end

endmodule
